// File: sv/planar_span_fill_masks_core_macros.svh
// Assertion macros for the span fill core checker.
// Included by psf_checker.sv; no other dependencies.
`ifndef PLANAR_SPAN_FILL_MASKS_CORE_MACROS_SVH
`define PLANAR_SPAN_FILL_MASKS_CORE_MACROS_SVH

// implication checked every cycle outside reset
`define PSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define PSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication with no reset qualifier
`define PSF_ASSERT_RAW(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/psf_pkg.sv
// Shared types and constants for the planar span fill core.
// No dependencies.
`default_nettype none
package psf_pkg;

    localparam logic [7:0] FULL_MASK = 8'hff;
    localparam logic [6:0] CNT_MAX   = 7'd127;

    // piece slots in a span descriptor
    localparam int PC_LEAD  = 0;
    localparam int PC_MID   = 1;
    localparam int PC_TRAIL = 2;

    typedef struct packed {
        logic [2:0]  pend;
        logic [3:0]  color;
        logic [15:0] lead_off;
        logic [7:0]  lead_mask;
        logic [15:0] mid_off;
        logic [6:0]  mid_cnt;
        logic [7:0]  mid_mask;
        logic [15:0] trail_off;
        logic [7:0]  trail_mask;
    } t_desc;

    typedef struct packed {
        logic [15:0] off;
        logic [6:0]  cnt;
        logic [7:0]  mask;
        logic [3:0]  color;
        logic        last;
    } t_cmd;

endpackage
`default_nettype wire

// File: sv/psf_fifo.sv
// Small register FIFO used between front and back and at the output.
// Depends on nothing; DEPTH must be a power of two, at least 2.
`default_nettype none
module psf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + PW'(1);
            end
            if (w_rd) begin
                r_rp <= r_rp + PW'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

// File: sv/psf_front.sv
// Front end: holds the pattern register, orders the span ends and splits
// the span into lead, middle and trail pieces. Uses psf_pkg.
`default_nettype none
module psf_front #(
    parameter int ROW_BYTES = 80
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [63:0]   i_cfg_data,
    input  wire logic          i_push,
    input  wire logic          i_full,
    input  wire logic [9:0]    i_x_start,
    input  wire logic [9:0]    i_x_end,
    input  wire logic [8:0]    i_row,
    input  wire logic [3:0]    i_fill_color,
    input  wire logic          i_use_pattern,
    output logic               o_push,
    output psf_pkg::t_desc     o_desc
);
    import psf_pkg::*;

    localparam int RB_W = $clog2(ROW_BYTES + 1);

    logic [63:0]       r_pattern;
    logic [9:0]        w_xa, w_xb;
    logic [6:0]        w_first, w_final;
    logic [2:0]        w_s, w_e;
    logic [7:0]        w_pat, w_lm, w_tm, w_cnt;
    logic [9+RB_W-1:0] w_prod;
    logic [31:0]       w_prod_ext;
    logic [15:0]       w_base;
    logic              w_lead, w_trail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '1;
        end else if (i_cfg_we) begin
            r_pattern <= i_cfg_data;
        end
    end

    always_comb begin
        if (i_x_start > i_x_end) begin
            w_xa = i_x_end;
            w_xb = i_x_start;
        end else begin
            w_xa = i_x_start;
            w_xb = i_x_end;
        end
        w_first    = w_xa[9:3];
        w_final    = w_xb[9:3];
        w_s        = w_xa[2:0];
        w_e        = w_xb[2:0];
        w_pat      = i_use_pattern ? r_pattern[{i_row[2:0], 3'b000} +: 8] : FULL_MASK;
        w_prod     = (9+RB_W)'(i_row) * (9+RB_W)'(ROW_BYTES);
        w_prod_ext = 32'(w_prod);
        w_base     = w_prod_ext[15:0];
        w_lm       = FULL_MASK >> w_s;
        w_tm       = FULL_MASK << (3'd7 - w_e);
        w_lead     = (w_s != 3'd0);
        w_trail    = (w_e != 3'd7);
        w_cnt      = {1'b0, w_final} - {1'b0, w_first} + 8'd1
                     - {7'b0, w_lead} - {7'b0, w_trail};

        o_desc.color      = i_fill_color;
        o_desc.lead_off   = w_base + {9'b0, w_first};
        o_desc.mid_off    = w_base + {9'b0, w_first} + {15'b0, w_lead};
        o_desc.mid_cnt    = w_cnt[7] ? CNT_MAX : w_cnt[6:0];
        o_desc.mid_mask   = w_pat;
        o_desc.trail_off  = w_base + {9'b0, w_final};
        o_desc.trail_mask = w_tm & w_pat;
        if (w_first == w_final) begin
            o_desc.pend      = 3'b001;
            o_desc.lead_mask = w_lm & w_tm & w_pat;
        end else begin
            o_desc.pend[PC_LEAD]  = w_lead;
            o_desc.pend[PC_MID]   = (w_cnt != 8'd0);
            o_desc.pend[PC_TRAIL] = w_trail;
            o_desc.lead_mask      = w_lm & w_pat;
        end
    end

    assign o_push = i_push && !i_full;
endmodule
`default_nettype wire

// File: sv/psf_back.sv
// Back end: takes span descriptors and issues one write command per cycle while
// the command queue has room. Uses psf_pkg.
`default_nettype none
module psf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire psf_pkg::t_desc i_desc,
    input  wire logic          i_desc_empty,
    output logic               o_desc_pop,
    output psf_pkg::t_cmd      o_cmd,
    output logic               o_cmd_push,
    input  wire logic          i_cmd_full
);
    import psf_pkg::*;

    t_desc      r_cur;
    logic [2:0] r_pend;
    logic [2:0] w_rest;
    logic       w_have, w_emit, w_load;

    always_comb begin
        w_rest      = r_pend;
        o_cmd.color = r_cur.color;
        priority if (r_pend[PC_LEAD]) begin
            w_rest[PC_LEAD] = 1'b0;
            o_cmd.off       = r_cur.lead_off;
            o_cmd.cnt       = 7'd1;
            o_cmd.mask      = r_cur.lead_mask;
        end else if (r_pend[PC_MID]) begin
            w_rest[PC_MID] = 1'b0;
            o_cmd.off      = r_cur.mid_off;
            o_cmd.cnt      = r_cur.mid_cnt;
            o_cmd.mask     = r_cur.mid_mask;
        end else begin
            w_rest[PC_TRAIL] = 1'b0;
            o_cmd.off        = r_cur.trail_off;
            o_cmd.cnt        = 7'd1;
            o_cmd.mask       = r_cur.trail_mask;
        end
        o_cmd.last = (w_rest == 3'b000);
        w_have     = (r_pend != 3'b000);
        w_emit     = w_have && !i_cmd_full;
        w_load     = !i_desc_empty && (!w_have || (w_emit && o_cmd.last));
    end

    assign o_cmd_push = w_emit;
    assign o_desc_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cur <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 3'b000;
        end else if (w_load) begin
            r_pend <= i_desc.pend;
        end else if (w_emit) begin
            r_pend <= w_rest;
        end
    end
endmodule
`default_nettype wire

// File: sv/planar_span_fill_masks_core.sv
// Planar span fill core: one span request in, one to three write commands
// out (leading partial byte, full middle run, trailing partial byte). An
// accepted span is classified in the same cycle and queued; the back end
// issues one command word per cycle while the output queue has room, so the
// rate is set by that single command port. Spans are accepted back to back
// while the descriptor queue has room. The user must write the pattern register
// through i_cfg_we / i_cfg_data only while idle; the block does not enforce this.
// Depends on psf_pkg, psf_fifo, psf_front, psf_back.
`default_nettype none
module planar_span_fill_masks_core #(
    parameter int ROW_BYTES  = 80,
    parameter int DESC_DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [63:0]   i_cfg_data,
    input  wire logic          push,
    output logic               full,
    input  wire logic [9:0]    i_x_start,
    input  wire logic [9:0]    i_x_end,
    input  wire logic [8:0]    i_row,
    input  wire logic [3:0]    i_fill_color,
    input  wire logic          i_use_pattern,
    output logic               empty,
    input  wire logic          pop,
    output logic [15:0]        o_byte_offset,
    output logic [6:0]         o_byte_count,
    output logic [7:0]         o_pix_mask,
    output logic [3:0]         o_out_color,
    output logic               o_last
);
    import psf_pkg::*;

    localparam int DW = $bits(t_desc);
    localparam int CW = $bits(t_cmd);

    t_desc         w_fdesc, w_bdesc;
    t_cmd          w_cmd, w_out;
    logic [DW-1:0] w_bdesc_bits;
    logic [CW-1:0] w_out_bits;
    logic          w_dpush, w_dpop, w_dempty;
    logic          w_cpush, w_cfull;

    psf_front #(.ROW_BYTES(ROW_BYTES)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_full        (full),
        .i_x_start     (i_x_start),
        .i_x_end       (i_x_end),
        .i_row         (i_row),
        .i_fill_color  (i_fill_color),
        .i_use_pattern (i_use_pattern),
        .o_push        (w_dpush),
        .o_desc        (w_fdesc)
    );

    psf_fifo #(.WIDTH(DW), .DEPTH(DESC_DEPTH)) u_desc_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_dpush),
        .i_data  (w_fdesc),
        .o_full  (full),
        .i_pop   (w_dpop),
        .o_data  (w_bdesc_bits),
        .o_empty (w_dempty)
    );

    assign w_bdesc = t_desc'(w_bdesc_bits);

    psf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (w_bdesc),
        .i_desc_empty (w_dempty),
        .o_desc_pop   (w_dpop),
        .o_cmd        (w_cmd),
        .o_cmd_push   (w_cpush),
        .i_cmd_full   (w_cfull)
    );

    psf_fifo #(.WIDTH(CW), .DEPTH(2)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cpush),
        .i_data  (w_cmd),
        .o_full  (w_cfull),
        .i_pop   (pop),
        .o_data  (w_out_bits),
        .o_empty (empty)
    );

    assign w_out         = t_cmd'(w_out_bits);
    assign o_byte_offset = w_out.off;
    assign o_byte_count  = w_out.cnt;
    assign o_pix_mask    = w_out.mask;
    assign o_out_color   = w_out.color;
    assign o_last        = w_out.last;
endmodule
`default_nettype wire

// File: sv/psf_checker.sv
// Port-level checks for planar_span_fill_masks_core, bound to the top level.
// Depends on planar_span_fill_masks_core_macros.svh.
`default_nettype none
`include "planar_span_fill_masks_core_macros.svh"
module psf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [15:0] o_byte_offset,
    input wire logic [6:0]  o_byte_count,
    input wire logic [7:0]  o_pix_mask,
    input wire logic [3:0]  o_out_color,
    input wire logic        o_last
);
    `PSF_ASSERT_RAW(a_rst_idle, i_clk, !i_rst_n, empty && !full, "not idle after reset")
    `PSF_ASSERT_IMP(a_cnt_nz, i_clk, i_rst_n, !empty, o_byte_count != 7'd0, "zero byte count")
    `PSF_ASSERT_NXT(a_span_cont, i_clk, i_rst_n, !empty && pop && !o_last, !empty,
        "gap inside a span")
    `PSF_ASSERT_NXT(a_hold, i_clk, i_rst_n, !empty && !pop,
        !empty && $stable(o_byte_offset) && $stable(o_byte_count) && $stable(o_pix_mask)
        && $stable(o_out_color) && $stable(o_last), "word changed while waiting")
endmodule

bind planar_span_fill_masks_core psf_checker u_psf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_byte_offset (o_byte_offset),
    .o_byte_count  (o_byte_count),
    .o_pix_mask    (o_pix_mask),
    .o_out_color   (o_out_color),
    .o_last        (o_last)
);
`default_nettype wire
